FILE: rtl/core/track2_magstripe_decoder_assert.svh
// Assertion macros for the track 2 decoder core.
// Clock aclk and active-low reset aresetn must be in scope at each use.
`ifndef TRACK2_MAGSTRIPE_DECODER_ASSERT_SVH
`define TRACK2_MAGSTRIPE_DECODER_ASSERT_SVH

// same-cycle implication
`define TRK2_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TRK2_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/trk2_pkg.sv
// Shared types and constants for the track 2 decoder core.
// No dependencies; imported by controller, datapath and top level.
package trk2_pkg;

    localparam int CFG_W      = 9;
    localparam int CHAR_W     = 5;
    localparam int CHAR_BITS  = 5;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BIT   = 2'd1;
    localparam logic [1:0] OP_END   = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic [1:0] STAT_VALID   = 2'd0;
    localparam logic [1:0] STAT_ERROR   = 2'd1;
    localparam logic [1:0] STAT_STARTED = 2'd2;

    localparam logic [1:0] FLD_PAN  = 2'd0;
    localparam logic [1:0] FLD_ADD  = 2'd1;
    localparam logic [1:0] FLD_DISC = 2'd2;

    localparam logic [1:0] OUT_START = 2'd0;
    localparam logic [1:0] OUT_ERR   = 2'd1;
    localparam logic [1:0] OUT_CHAR  = 2'd2;

    localparam logic CFG_START_LIMIT = 1'b0;
    localparam logic CFG_END_LIMIT   = 1'b1;

    localparam logic [CFG_W-1:0] START_LIMIT_RST = 9'd200;
    localparam logic [CFG_W-1:0] END_LIMIT_RST   = 9'd245;

    localparam logic [CHAR_W-1:0] START_SENTINEL = 5'h0B;
    localparam logic [CHAR_W-1:0] FIELD_SEP      = 5'h0D;
    localparam logic [CHAR_W-1:0] END_SENTINEL   = 5'h1F;
    localparam logic [CHAR_W-1:0] DIGIT_MASK     = 5'h0F;

    localparam int ADD_COUNT  = 7;
    localparam int DISC_COUNT = 8;

    typedef struct packed {
        logic       latch_item;
        logic       clear_run;
        logic       set_swipe;
        logic       clr_swipe;
        logic       take_bit;
        logic       walk_start;
        logic       walk_next;
        logic       rd_issue;
        logic       out_load;
        logic [1:0] out_kind;
    } trk2_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       in_swipe;
        logic       run_ok;
        logic       walk_last;
        logic       out_free;
    } trk2_stat_t;

endpackage

FILE: rtl/core/trk2_dp.sv
// Datapath: item latch, bit framing, character memory, decode walk, output register.
// Depends on trk2_pkg; driven by trk2_ctrl commands.
module trk2_dp
    import trk2_pkg::*;
#(
    parameter int RAW_BITS  = 256,
    parameter int MAX_CHARS = 40,
    parameter int MAX_PAN   = 19
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  trk2_cmd_t        cmd,
    output trk2_stat_t       stat,
    input  logic [1:0]       s_operation,
    input  logic             s_data_pin_level,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [1:0]       m_status,
    output logic [1:0]       m_field,
    output logic [4:0]       m_char_value,
    output logic [4:0]       m_pan_length,
    output logic             m_last
);

    localparam int BC_W   = $clog2(RAW_BITS + 1);
    localparam int CI_W   = $clog2(MAX_CHARS + 1);
    localparam int IDX_W  = $clog2(MAX_CHARS);
    localparam int CMP_W  = (BC_W > CFG_W) ? BC_W : CFG_W;
    localparam int SUM_W  = CI_W + 1;
    localparam int PAN_CW = IDX_W + 1;
    localparam int TAIL   = ADD_COUNT + DISC_COUNT;

    logic [1:0]        op_reg;
    logic              pin_reg;
    logic              in_swipe_reg;
    logic [CFG_W-1:0]  start_limit_reg;
    logic [CFG_W-1:0]  end_limit_reg;

    logic [BC_W-1:0]   bit_count_reg,  bit_count_next;
    logic [4:0]        window_reg,     window_next;
    logic              synced_reg,     synced_next;
    logic [2:0]        phase_reg,      phase_next;
    logic [CI_W-1:0]   char_index_reg, char_index_next;
    logic [IDX_W-1:0]  sep_index_reg,  sep_index_next;
    logic              sep_seen_reg,   sep_seen_next;
    logic              end_seen_reg,   end_seen_next;
    logic              fault_reg,      fault_next;

    logic [CHAR_W-1:0] mem [MAX_CHARS];
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [CHAR_W-1:0] mem_wdata;
    logic [CHAR_W-1:0] rdata_reg;

    logic [CI_W-1:0]   walk_reg;
    logic [IDX_W-1:0]  pan;
    logic              walk_in_pan;
    logic              walk_in_add;
    logic [IDX_W-1:0]  rd_addr;

    logic              m_valid_reg;
    logic [1:0]        m_status_reg;
    logic [1:0]        m_field_reg;
    logic [4:0]        m_char_reg;
    logic [4:0]        m_pan_reg;
    logic              m_last_reg;

    always_comb begin
        logic              bit_in;
        logic [BC_W-1:0]   cnt1;
        logic [BC_W-1:0]   cnt_pos;
        logic [4:0]        shifted;
        logic [4:0]        ch;

        bit_in          = ~pin_reg;
        cnt1            = bit_count_reg + BC_W'(1);
        cnt_pos         = cnt1 - BC_W'(CHAR_BITS);
        shifted         = {bit_in, window_reg[4:1]};
        ch              = window_reg | (5'(bit_in) << phase_reg);

        bit_count_next  = bit_count_reg;
        window_next     = window_reg;
        synced_next     = synced_reg;
        phase_next      = phase_reg;
        char_index_next = char_index_reg;
        sep_index_next  = sep_index_reg;
        sep_seen_next   = sep_seen_reg;
        end_seen_next   = end_seen_reg;
        fault_next      = fault_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = ch;

        if (bit_count_reg < BC_W'(RAW_BITS)) begin
            bit_count_next = cnt1;
            if (!end_seen_reg) begin
                if (!synced_reg) begin
                    window_next = shifted;
                    if (cnt1 >= BC_W'(CHAR_BITS) && shifted == START_SENTINEL &&
                        CMP_W'(cnt_pos) < CMP_W'(start_limit_reg)) begin
                        synced_next     = 1'b1;
                        mem_we          = 1'b1;
                        mem_waddr       = '0;
                        mem_wdata       = START_SENTINEL;
                        char_index_next = CI_W'(1);
                        phase_next      = '0;
                        window_next     = '0;
                    end
                end else if (phase_reg != 3'(CHAR_BITS - 1)) begin
                    window_next = ch;
                    phase_next  = phase_reg + 3'd1;
                end else begin
                    phase_next  = '0;
                    window_next = '0;
                    if (char_index_reg < CI_W'(MAX_CHARS)) begin
                        if (!(^ch)) begin
                            fault_next = 1'b1;
                        end
                        mem_we          = 1'b1;
                        mem_waddr       = char_index_reg[IDX_W-1:0];
                        char_index_next = char_index_reg + CI_W'(1);
                        if (ch == FIELD_SEP && !sep_seen_reg) begin
                            sep_seen_next  = 1'b1;
                            sep_index_next = char_index_reg[IDX_W-1:0];
                        end
                        if (ch == END_SENTINEL) begin
                            end_seen_next = 1'b1;
                            if (CMP_W'(cnt_pos) >= CMP_W'(end_limit_reg)) begin
                                fault_next = 1'b1;
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_swipe_reg    <= 1'b0;
            start_limit_reg <= START_LIMIT_RST;
            end_limit_reg   <= END_LIMIT_RST;
            bit_count_reg   <= '0;
            window_reg      <= '0;
            synced_reg      <= 1'b0;
            phase_reg       <= '0;
            char_index_reg  <= '0;
            sep_index_reg   <= '0;
            sep_seen_reg    <= 1'b0;
            end_seen_reg    <= 1'b0;
            fault_reg       <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_START_LIMIT: start_limit_reg <= cfg_data;
                    CFG_END_LIMIT:   end_limit_reg   <= cfg_data;
                endcase
            end
            if (cmd.set_swipe) begin
                in_swipe_reg <= 1'b1;
            end else if (cmd.clr_swipe) begin
                in_swipe_reg <= 1'b0;
            end
            if (cmd.clear_run) begin
                bit_count_reg  <= '0;
                window_reg     <= '0;
                synced_reg     <= 1'b0;
                phase_reg      <= '0;
                char_index_reg <= '0;
                sep_index_reg  <= '0;
                sep_seen_reg   <= 1'b0;
                end_seen_reg   <= 1'b0;
                fault_reg      <= 1'b0;
            end else if (cmd.take_bit) begin
                bit_count_reg  <= bit_count_next;
                window_reg     <= window_next;
                synced_reg     <= synced_next;
                phase_reg      <= phase_next;
                char_index_reg <= char_index_next;
                sep_index_reg  <= sep_index_next;
                sep_seen_reg   <= sep_seen_next;
                end_seen_reg   <= end_seen_next;
                fault_reg      <= fault_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_item) begin
            op_reg  <= s_operation;
            pin_reg <= s_data_pin_level;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_bit && mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.rd_issue) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign pan         = sep_index_reg - IDX_W'(1);
    assign walk_in_pan = SUM_W'(walk_reg) < SUM_W'(pan);
    assign walk_in_add = SUM_W'(walk_reg) < SUM_W'(pan) + SUM_W'(ADD_COUNT);
    assign rd_addr     = IDX_W'(SUM_W'(walk_reg) + (walk_in_pan ? SUM_W'(1) : SUM_W'(2)));

    always_ff @(posedge aclk) begin
        if (cmd.walk_start) begin
            walk_reg <= '0;
        end else if (cmd.walk_next) begin
            walk_reg <= walk_reg + CI_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            unique case (cmd.out_kind)
                OUT_START: begin
                    m_status_reg <= STAT_STARTED;
                    m_field_reg  <= FLD_PAN;
                    m_char_reg   <= '0;
                    m_pan_reg    <= '0;
                    m_last_reg   <= 1'b1;
                end
                OUT_CHAR: begin
                    m_status_reg <= STAT_VALID;
                    m_pan_reg    <= 5'(pan);
                    m_last_reg   <= stat.walk_last;
                    if (walk_in_pan) begin
                        m_field_reg <= FLD_PAN;
                        m_char_reg  <= rdata_reg & DIGIT_MASK;
                    end else begin
                        m_field_reg <= walk_in_add ? FLD_ADD : FLD_DISC;
                        m_char_reg  <= rdata_reg;
                    end
                end
                default: begin
                    m_status_reg <= STAT_ERROR;
                    m_field_reg  <= FLD_PAN;
                    m_char_reg   <= '0;
                    m_pan_reg    <= '0;
                    m_last_reg   <= 1'b1;
                end
            endcase
        end
    end

    assign stat.op        = op_reg;
    assign stat.in_swipe  = in_swipe_reg;
    assign stat.run_ok    = synced_reg && end_seen_reg && sep_seen_reg && !fault_reg &&
                            (sep_index_reg != '0) &&
                            (PAN_CW'(sep_index_reg) <= PAN_CW'(MAX_PAN + 1)) &&
                            (SUM_W'(sep_index_reg) + SUM_W'(TAIL + 1) < SUM_W'(char_index_reg));
    assign stat.walk_last = SUM_W'(walk_reg) == SUM_W'(pan) + SUM_W'(TAIL - 1);
    assign stat.out_free  = !m_valid_reg || m_ready;

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_field      = m_field_reg;
    assign m_char_value = m_char_reg;
    assign m_pan_length = m_pan_reg;
    assign m_last       = m_last_reg;

endmodule

FILE: rtl/core/trk2_ctrl.sv
// Controller: sequences item execution and the swipe-end decode walk.
// Depends on trk2_pkg and the assertion macro header; drives trk2_dp.
`include "track2_magstripe_decoder_assert.svh"
module trk2_ctrl
    import trk2_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  trk2_stat_t stat,
    output trk2_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_ERR  = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0] state_reg, state_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.latch_item = 1'b1;
                    state_next     = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (stat.op)
                    OP_START: begin
                        if (stat.out_free) begin
                            cmd.clear_run = 1'b1;
                            cmd.set_swipe = 1'b1;
                            cmd.out_load  = 1'b1;
                            cmd.out_kind  = OUT_START;
                            state_next    = S_IDLE;
                        end
                    end
                    OP_BIT: begin
                        cmd.take_bit = stat.in_swipe;
                        state_next   = S_IDLE;
                    end
                    OP_END: begin
                        if (!stat.in_swipe) begin
                            state_next = S_IDLE;
                        end else begin
                            cmd.clr_swipe = 1'b1;
                            if (stat.run_ok) begin
                                cmd.walk_start = 1'b1;
                                state_next     = S_RD;
                            end else begin
                                state_next = S_ERR;
                            end
                        end
                    end
                    default: begin
                        cmd.clear_run = 1'b1;
                        cmd.clr_swipe = 1'b1;
                        state_next    = S_IDLE;
                    end
                endcase
            end
            S_ERR: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = OUT_ERR;
                    state_next   = S_IDLE;
                end
            end
            S_RD: begin
                cmd.rd_issue = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT: begin
                if (stat.out_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.out_kind  = OUT_CHAR;
                    cmd.walk_next = 1'b1;
                    state_next    = stat.walk_last ? S_IDLE : S_RD;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    `TRK2_ASSERT_NOW(a_load_when_free, cmd.out_load, stat.out_free, "output overwritten")
    `TRK2_ASSERT_NOW(a_bit_in_swipe, cmd.take_bit, stat.in_swipe, "bit taken outside swipe")
    `TRK2_ASSERT_NEXT(a_walk_done, (state_reg == S_EMIT) && stat.out_free && stat.walk_last, (state_reg == S_IDLE) && !cmd.rd_issue, "walk did not end")
    `TRK2_ASSERT_NEXT(a_read_then_emit, state_reg == S_RD, state_reg == S_EMIT && !s_ready, "read not followed by emit")

endmodule

FILE: rtl/core/track2_magstripe_decoder.sv
// Track 2 card stripe decoder: one item at a time is accepted (S_IDLE) and then executed (S_EXEC).
// A swipe start result is registered from S_EXEC and an error result from S_ERR; swipe end
// with a good card: 15 to 34 results, each a character memory read (S_RD) and then an output
// register load (S_EMIT) before the next read; a full output register stalls each result.
// aresetn (synchronous, active low) clears control state and sets the search limits to
// 200 and 245; the character memory is not cleared.
module track2_magstripe_decoder
    import trk2_pkg::*;
#(
    parameter int RAW_BITS  = 256,
    parameter int MAX_CHARS = 40,
    parameter int MAX_PAN   = 19
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_operation,
    input  logic             s_data_pin_level,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [1:0]       m_status,
    output logic [1:0]       m_field,
    output logic [4:0]       m_char_value,
    output logic [4:0]       m_pan_length,
    output logic             m_last,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    trk2_cmd_t  cmd;
    trk2_stat_t stat;

    assign cfg_ready = 1'b1;

    trk2_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    trk2_dp #(
        .RAW_BITS  (RAW_BITS),
        .MAX_CHARS (MAX_CHARS),
        .MAX_PAN   (MAX_PAN)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .s_operation      (s_operation),
        .s_data_pin_level (s_data_pin_level),
        .cfg_we           (cfg_valid & cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_field          (m_field),
        .m_char_value     (m_char_value),
        .m_pan_length     (m_pan_length),
        .m_last           (m_last)
    );

endmodule
